@@ sv/scvp_pkg.sv @@
// ----------------------------------------------------------------------------
// S-curve velocity profile package
// Shared codes, command and status structures for the profile generator.
// ----------------------------------------------------------------------------
package scvp_pkg;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  // Iteration counts of the shared divider.
  localparam logic [6:0] DIV_STEPS_WIDE   = 7'd64;
  localparam logic [6:0] DIV_STEPS_NARROW = 7'd32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MAX_VELOCITY = 2'd0,
    CFG_MAX_ACCEL    = 2'd1,
    CFG_MAX_JERK     = 2'd2,
    CFG_DISTANCE     = 2'd3
  } cfg_index_t;

  // Profile segments; the last code means the target is held.
  typedef enum logic [2:0] {
    SEG_JERK_UP   = 3'd0,
    SEG_CONST_ACC = 3'd1,
    SEG_JERK_DOWN = 3'd2,
    SEG_CRUISE    = 3'd3,
    SEG_DEC_UP    = 3'd4,
    SEG_CONST_DEC = 3'd5,
    SEG_DEC_DOWN  = 3'd6,
    SEG_HOLD      = 3'd7
  } seg_t;

  // Operand choice of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_ACC_SQ = 2'd1,
    MUL_FIRST  = 2'd2,
    MUL_SECOND = 2'd3
  } mul_op_t;

  // Which quotient the divider is working on.
  typedef enum logic [1:0] {
    DIV_A2J = 2'd0,
    DIV_B0  = 2'd1,
    DIV_B1  = 2'd2,
    DIV_B3  = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    mul_op_t  mul_op;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_capture;
    logic     select;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic square_seg;
    logic out_busy;
  } status_t;

endpackage

@@ sv/scvp_div.sv @@
// ----------------------------------------------------------------------------
// S-curve profile divider
// Restoring divider, one quotient bit per cycle, 64 or 32 steps.
// ----------------------------------------------------------------------------
module scvp_div import scvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        wide,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [31:0] rem;
  logic [63:0] qn;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] rem_step;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    rem_sh   = {rem, qn[63]};
    ge       = rem_sh >= {1'b0, den};
    rem_step = ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= wide ? DIV_STEPS_WIDE : DIV_STEPS_NARROW;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // In the narrow form the upper numerator half is already below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= wide ? 32'd0 : num[63:32];
      qn  <= wide ? num : {num[31:0], 32'd0};
    end else if (busy) begin
      rem <= rem_step;
      qn  <= {qn[62:0], ge};
    end
  end

  assign quo = qn;

endmodule

@@ sv/scvp_ctrl.sv @@
// ----------------------------------------------------------------------------
// S-curve profile controller
// Sequences the multiplier, divider, segment select and result per tick.
// ----------------------------------------------------------------------------
module scvp_ctrl import scvp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_MUL_ACC    = 8'b0000_0010,
    ST_DIV_START  = 8'b0000_0100,
    ST_DIV_WAIT   = 8'b0000_1000,
    ST_SELECT     = 8'b0001_0000,
    ST_MUL_FIRST  = 8'b0010_0000,
    ST_MUL_SECOND = 8'b0100_0000,
    ST_FINISH     = 8'b1000_0000
  } state_t;

  state_t   state, state_next;
  div_sel_t div_sel, div_sel_next;

  // No request is taken while reset is held.
  assign s_tready = (state == ST_IDLE) && !rst;

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = div_sel;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.accept = 1'b1;
          state_next = ST_MUL_ACC;
        end
      end
      ST_MUL_ACC: begin
        cmd.mul_op = MUL_ACC_SQ;
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_capture = 1'b1;
          state_next      = (div_sel == DIV_B3) ? ST_SELECT : ST_DIV_START;
        end
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = ST_MUL_FIRST;
      end
      ST_MUL_FIRST: begin
        cmd.mul_op = MUL_FIRST;
        state_next = status.square_seg ? ST_MUL_SECOND : ST_FINISH;
      end
      ST_MUL_SECOND: begin
        cmd.mul_op = MUL_SECOND;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Walk through the four quotients in order.
  always_comb begin
    div_sel_next = div_sel;
    if (cmd.accept) begin
      div_sel_next = DIV_A2J;
    end else if (cmd.div_capture) begin
      case (div_sel)
        DIV_A2J: div_sel_next = DIV_B0;
        DIV_B0:  div_sel_next = DIV_B1;
        DIV_B1:  div_sel_next = DIV_B3;
        default: div_sel_next = DIV_A2J;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_sel <= DIV_A2J;
    end else begin
      state   <= state_next;
      div_sel <= div_sel_next;
    end
  end

endmodule

@@ sv/scvp_dp.sv @@
// ----------------------------------------------------------------------------
// S-curve profile datapath
// Configuration, time base, boundaries, shared multiplier and result register.
// ----------------------------------------------------------------------------
module scvp_dp import scvp_pkg::*; #(
  parameter int TICKS_PER_SECOND = 100,
  parameter int FRAC_BITS        = 16,
  parameter int TICK_WIDTH       = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        restart,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata
);

  localparam int TT    = TICK_WIDTH + FRAC_BITS;
  localparam int RW    = $clog2(TICKS_PER_SECOND) + 1;
  localparam int T_INC = (1 << FRAC_BITS) / TICKS_PER_SECOND;
  localparam int T_REM = (1 << FRAC_BITS) % TICKS_PER_SECOND;

  function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic logic [31:0] sat_64(input logic [63:0] x);
    return (x > {32'd0, MAX32}) ? MAX32 : x[31:0];
  endfunction

  function automatic logic [31:0] sub_floor(input logic [63:0] x, input logic [63:0] y);
    return (x > y) ? sat_64(x - y) : 32'd0;
  endfunction

  logic [31:0] max_velocity, max_accel, max_jerk, distance;
  logic [TICK_WIDTH-1:0] tick_count;
  logic [TT-1:0]         t;
  logic [RW-1:0]         t_rem;
  logic [RW-1:0]         rem_sum;
  logic [31:0] bd0, bd1, bd3, bd2, bd4, bd5, bd6;
  logic [63:0] half_a2j;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [31:0] held_target;
  logic [31:0] target;
  logic [31:0] delta;
  seg_t        seg, seg_sel;
  logic        finished, finished_sel;
  logic [31:0] delta_sel;
  logic [63:0] t64;
  logic [63:0] pq;
  logic [31:0] hjs;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [63:0] div_quo;
  logic [31:0] q32;

  // Writes are taken at any time outside reset.
  assign cfg_ready = ~rst;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity <= 32'h0001_0000;
      max_accel    <= 32'h0001_0000;
      max_jerk     <= 32'h0001_0000;
      distance     <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_VELOCITY: max_velocity <= cfg_data;
        CFG_MAX_ACCEL:    max_accel    <= cfg_data;
        CFG_MAX_JERK:     max_jerk     <= cfg_data;
        CFG_DISTANCE:     distance     <= cfg_data;
        default:          distance     <= distance;
      endcase
    end
  end

  // Time base: t tracks tick_count * 2^FRAC_BITS / TICKS_PER_SECOND exactly.
  assign rem_sum = t_rem + RW'(T_REM);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      t          <= '0;
      t_rem      <= '0;
    end else if (cmd.accept && restart) begin
      tick_count <= '0;
      t          <= '0;
      t_rem      <= '0;
    end else if (cmd.finish && (tick_count != '1)) begin
      tick_count <= tick_count + 1'b1;
      if (rem_sum >= RW'(TICKS_PER_SECOND)) begin
        t_rem <= rem_sum - RW'(TICKS_PER_SECOND);
        t     <= t + TT'(T_INC) + 1'b1;
      end else begin
        t_rem <= rem_sum;
        t     <= t + TT'(T_INC);
      end
    end
  end

  // Divider operands per quotient.
  always_comb begin
    case (cmd.div_sel)
      DIV_A2J: begin
        div_num = prod;
        div_den = max_jerk;
      end
      DIV_B0: begin
        div_num = 64'(max_accel) << FRAC_BITS;
        div_den = max_jerk;
      end
      DIV_B1: begin
        div_num = 64'(max_velocity) << FRAC_BITS;
        div_den = max_accel;
      end
      default: begin
        div_num = 64'(distance) << FRAC_BITS;
        div_den = max_velocity;
      end
    endcase
    q32 = (div_num[63:32] >= div_den) ? MAX32 : div_quo[31:0];
  end

  scvp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .wide  (cmd.div_sel == DIV_A2J),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_capture) begin
      case (cmd.div_sel)
        DIV_A2J: half_a2j <= div_quo >> 1;
        DIV_B0:  bd0      <= q32;
        DIV_B1:  bd1      <= q32;
        default: bd3      <= q32;
      endcase
    end
  end

  // Derived boundaries.
  always_comb begin
    bd2 = sat_add(bd0, bd1);
    bd4 = sat_add(bd0, bd3);
    bd5 = sat_add(bd1, bd3);
    bd6 = sat_add(bd5, bd0);
  end

  // Segment select and the time offset used in that segment.
  always_comb begin
    t64          = 64'(t);
    finished_sel = t64 >= {32'd0, bd6};
    delta_sel    = 32'd0;
    if (t64 < {32'd0, bd0}) begin
      seg_sel   = SEG_JERK_UP;
      delta_sel = t[31:0];
    end else if (t64 < {32'd0, bd1}) begin
      seg_sel   = SEG_CONST_ACC;
      delta_sel = t[31:0];
    end else if (t64 >= {32'd0, bd1} && t64 < {32'd0, bd2}) begin
      seg_sel   = SEG_JERK_DOWN;
      delta_sel = 32'({32'd0, bd2} - t64);
    end else if (t64 >= {32'd0, bd2} && t64 < {32'd0, bd3}) begin
      seg_sel   = SEG_CRUISE;
    end else if (t64 >= {32'd0, bd3} && t64 < {32'd0, bd4}) begin
      seg_sel   = SEG_DEC_UP;
      delta_sel = 32'(t64 - {32'd0, bd3});
    end else if (t64 >= {32'd0, bd4} && t64 < {32'd0, bd5}) begin
      seg_sel   = SEG_CONST_DEC;
      delta_sel = 32'(t64 - {32'd0, bd3});
    end else if (t64 >= {32'd0, bd5} && t64 < {32'd0, bd6}) begin
      seg_sel   = SEG_DEC_DOWN;
      delta_sel = 32'({32'd0, bd6} - t64);
    end else begin
      seg_sel   = SEG_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      seg      <= seg_sel;
      finished <= finished_sel;
      delta    <= delta_sel;
    end
  end

  assign status.square_seg = seg inside {SEG_JERK_UP, SEG_JERK_DOWN, SEG_DEC_UP, SEG_DEC_DOWN};
  assign status.div_done   = div_done;
  assign status.out_busy   = m_tvalid & ~m_tready;

  // Shared multiplier, product registered.
  assign pq = prod >> FRAC_BITS;

  always_comb begin
    case (cmd.mul_op)
      MUL_ACC_SQ: begin
        mul_a = max_accel;
        mul_b = max_accel;
      end
      MUL_FIRST: begin
        mul_a = status.square_seg ? delta : max_accel;
        mul_b = delta;
      end
      MUL_SECOND: begin
        mul_a = max_jerk;
        mul_b = sat_64(pq);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // Target for the selected segment.
  assign hjs = sat_64(pq >> 1);

  always_comb begin
    case (seg)
      SEG_JERK_UP, SEG_DEC_DOWN: target = hjs;
      SEG_CONST_ACC:             target = sub_floor(pq, half_a2j);
      SEG_JERK_DOWN, SEG_DEC_UP: target = sub_floor(64'(max_velocity), 64'(hjs));
      SEG_CRUISE:                target = max_velocity;
      SEG_CONST_DEC:             target = sub_floor(64'(max_velocity) + half_a2j, pq);
      default:                   target = held_target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_target <= 32'd0;
    end else if (cmd.finish) begin
      held_target <= target;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {4'd0, finished, seg, target};
    end
  end

endmodule

@@ sv/scurve_velocity_profile_core.sv @@
// ----------------------------------------------------------------------------
// S-curve velocity profile core
// Jerk-limited seven-segment velocity setpoint generator, one result per tick.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ side is one control tick; s_tdata bit 0 set
// restarts the move at time zero before that tick is evaluated. Each tick
// yields one request on the m_ side with the velocity target, the segment
// (7 means finished and holding) and the finished flag.
// Limits and distance must be written over the cfg_ port (ready outside reset)
// only while the block is idle; the block itself does not enforce this.
// Each tick runs a multiply, then the shared divider at one quotient bit per
// cycle: 64 steps for a^2/j and 32 steps for each of the three boundary
// times, each quotient with a start and a capture step; then the select, the
// first multiply, the second multiply (skipped in the linear segments) and
// the finish step. One tick is worked at a time: the next request is accepted
// only once the last one has left the finish step.
// The result sits in an output register; the next tick is accepted while it
// waits, and the core only holds in its last step if the receiver stalls.
// Reset (rst, synchronous) sets time and the held target to zero and loads
// limits of 1.0 with a zero distance; no request is taken during reset.
module scurve_velocity_profile_core import scvp_pkg::*; #(
  parameter int TICKS_PER_SECOND = 100,
  parameter int FRAC_BITS        = 16,
  parameter int TICK_WIDTH       = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] velocity_target, [34:32] segment,
                                 // [35] finished, [39:36] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  scvp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  scvp_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .FRAC_BITS        (FRAC_BITS),
    .TICK_WIDTH       (TICK_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .restart   (s_tdata[0]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
